// ----- src/p16e10_pkg.sv -----
// Shared constants, types and helper functions for the posit16 exp10 unit.
package p16e10_pkg;

    localparam int QDepth = 4;

    localparam logic [15:0] NAR        = 16'h8000;
    localparam logic [15:0] MINPOS     = 16'h0001;
    localparam logic [15:0] MAXPOS     = 16'h7FFF;
    localparam logic [15:0] ONE        = 16'h4000;
    localparam logic [15:0] NEG_SAT_HI = 16'h97DF;
    localparam logic [15:0] POS_SAT_LO = 16'h6821;
    localparam logic [15:0] ZERO_NEG   = 16'hFFA9;
    localparam logic [15:0] ZERO_POS   = 16'h0077;

    localparam logic [31:0] LOG2_10_LO = 32'h0979A371;
    localparam logic [20:0] LOG2_10_HI = 21'h1A934F;

    localparam logic [41:0]  DEC_Q       = 42'd3814697265625;
    localparam logic [127:0] DEC_RECIP_W = ((128'd1 << 104) + {86'b0, DEC_Q} - 128'd1)
                                         / {86'b0, DEC_Q};
    localparam logic [62:0]  DEC_RECIP   = DEC_RECIP_W[62:0];

    localparam logic [63:0] COEF [0:6] = '{
        64'd1000000080000129410,
        64'd693141854936602630,
        64'd240282388412963510,
        64'd55274346317151946,
        64'd10068022050595113,
        64'd903183855396511,
        64'd330194785190027
    };

    typedef struct packed {
        logic              spec;
        logic [15:0]       spec_res;
        logic signed [7:0] n;
    } side_t;

    typedef struct packed {
        side_t       side;
        logic [63:0] f64;
    } qitem_t;

    function automatic logic [4:0] lzc16(input logic [15:0] x);
        logic [4:0] c;
        c = 5'd16;
        for (int i = 0; i < 16; i++)
        begin
            if (x[i])
            begin
                c = 5'(15 - i);
            end
        end
        return c;
    endfunction

    function automatic logic [5:0] lzc62(input logic [61:0] x);
        logic [5:0] c;
        c = 6'd62;
        for (int i = 0; i < 62; i++)
        begin
            if (x[i])
            begin
                c = 6'(61 - i);
            end
        end
        return c;
    endfunction

endpackage

// ----- src/posit16_exp10_top.sv -----
// Top level of the posit16 (es=1) ten-to-the-power-x unit.
//
//  channel | direction | tdata fields (low bit up)  | tuser/tlast
//  s_axis  | in        | x_posit[15:0]               | none
//  m_axis  | out       | result_posit[15:0]          | none
//
//  Takes one transaction per cycle unless a full queue stalls the front end;
//  the path runs through the front stages, the queue and the back end (six
//  multiply-add steps, 5 reciprocal conversion steps, 4 rounding steps).
//  Reset clears only valid bits and queue pointers and count; no clearing pass.
//  A stalled output holds the back end; the front end keeps going until the
//  queue fills.
module posit16_exp10_top #(
    parameter int QDEPTH = p16e10_pkg::QDepth
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // x_posit[15:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // result_posit[15:0]
);

    logic               q_full, q_empty, push, pop;
    p16e10_pkg::qitem_t push_item, head;

    p16e10_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .x_posit   (s_tdata),
        .q_full    (q_full),
        .push      (push),
        .push_item (push_item)
    );

    p16e10_queue #(.DEPTH(QDEPTH)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .head      (head),
        .empty     (q_empty)
    );

    p16e10_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .head         (head),
        .pop          (pop),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .result_posit (m_tdata)
    );

endmodule

// ----- src/p16e10_front.sv -----
// Front end: accept, classify, decode and scale the argument into integer and fraction.
module p16e10_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [15:0]          x_posit,
    input  logic                 q_full,
    output logic                 push,
    output p16e10_pkg::qitem_t   push_item
);

    logic [3:0] vld_reg;
    logic       f_en;

    assign f_en     = !vld_reg[3] || !q_full;
    assign in_ready = f_en;
    assign push     = f_en && vld_reg[3];

    // decode
    logic              neg;
    logic [15:0]       u, bits, xb, rest;
    logic              lead, ebit;
    logic [4:0]        lz;
    logic [3:0]        run;
    logic signed [5:0] k;
    logic signed [7:0] kk, tt;
    logic [5:0]        t_next;
    logic [12:0]       sig_next;
    p16e10_pkg::side_t side_next;

    always_comb
    begin
        neg  = x_posit[15];
        u    = neg ? (~x_posit + 16'd1) : x_posit;
        bits = {u[14:0], 1'b0};
        lead = bits[15];
        xb   = lead ? ~bits : bits;
        lz   = p16e10_pkg::lzc16(xb);
        run  = (lz > 5'd15) ? 4'd15 : lz[3:0];
        rest = 16'(bits << ({1'b0, run} + 5'd1));
        ebit = rest[15];
        sig_next = {1'b1, rest[14:3]};
        k    = lead ? ($signed({2'b0, run}) - 6'sd1) : -$signed({2'b0, run});
        kk   = {{2{k[5]}}, k};
        tt   = 8'sd5 - (kk <<< 1) - $signed({7'b0, ebit});
        if (tt < 8'sd2)
        begin
            t_next = 6'd2;
        end
        else if (tt > 8'sd32)
        begin
            t_next = 6'd32;
        end
        else
        begin
            t_next = tt[5:0];
        end

        side_next.n = 8'sd0;
        side_next.spec = 1'b1;
        if (x_posit > p16e10_pkg::NAR && x_posit <= p16e10_pkg::NEG_SAT_HI)
        begin
            side_next.spec_res = p16e10_pkg::MINPOS;
        end
        else if (x_posit >= p16e10_pkg::POS_SAT_LO && x_posit < p16e10_pkg::NAR)
        begin
            side_next.spec_res = p16e10_pkg::MAXPOS;
        end
        else if (x_posit == p16e10_pkg::NAR)
        begin
            side_next.spec_res = p16e10_pkg::NAR;
        end
        else if (x_posit >= p16e10_pkg::ZERO_NEG || x_posit <= p16e10_pkg::ZERO_POS)
        begin
            side_next.spec_res = p16e10_pkg::ONE;
        end
        else
        begin
            side_next.spec     = 1'b0;
            side_next.spec_res = p16e10_pkg::ONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (f_en)
        begin
            vld_reg <= {vld_reg[2:0], in_valid};
        end
    end

    // stage 1: decoded fields
    logic [12:0]       sig1_reg;
    logic [5:0]        t1_reg;
    logic              neg1_reg;
    p16e10_pkg::side_t side1_reg;

    always_ff @(posedge clk)
    begin
        if (f_en)
        begin
            sig1_reg  <= sig_next;
            t1_reg    <= t_next;
            neg1_reg  <= neg;
            side1_reg <= side_next;
        end
    end

    // stage 2: partial products with log2(10)
    logic [44:0]       plo2_reg;
    logic [33:0]       phi2_reg;
    logic [5:0]        t2_reg;
    logic              neg2_reg;
    p16e10_pkg::side_t side2_reg;

    always_ff @(posedge clk)
    begin
        if (f_en)
        begin
            plo2_reg  <= {32'b0, sig1_reg} * {13'b0, p16e10_pkg::LOG2_10_LO};
            phi2_reg  <= {21'b0, sig1_reg} * {13'b0, p16e10_pkg::LOG2_10_HI};
            t2_reg    <= t1_reg;
            neg2_reg  <= neg1_reg;
            side2_reg <= side1_reg;
        end
    end

    // stage 3: align and sum
    logic [63:0]       q3_reg;
    logic              neg3_reg;
    p16e10_pkg::side_t side3_reg;
    logic [63:0]       q_next;

    assign q_next = ({30'b0, phi2_reg} << (6'd32 - t2_reg)) + ({19'b0, plo2_reg} >> t2_reg);

    always_ff @(posedge clk)
    begin
        if (f_en)
        begin
            q3_reg    <= q_next;
            neg3_reg  <= neg2_reg;
            side3_reg <= side2_reg;
        end
    end

    // stage 4: split into integer and fraction
    logic [5:0]        q58;
    logic [57:0]       fr, f_next;
    logic signed [7:0] nneg;
    p16e10_pkg::side_t side4_next;
    p16e10_pkg::qitem_t item4_reg;

    always_comb
    begin
        q58  = q3_reg[63:58];
        fr   = q3_reg[57:0];
        nneg = -$signed({2'b0, q58});
        side4_next = side3_reg;
        if (!neg3_reg)
        begin
            side4_next.n = $signed({2'b0, q58});
            f_next = fr;
        end
        else if (fr == 58'd0)
        begin
            side4_next.n = nneg;
            f_next = 58'd0;
        end
        else
        begin
            side4_next.n = nneg - 8'sd1;
            f_next = 58'((59'd1 << 58) - {1'b0, fr});
        end
    end

    always_ff @(posedge clk)
    begin
        if (f_en)
        begin
            item4_reg.side <= side4_next;
            item4_reg.f64  <= {f_next, 6'b0};
        end
    end

    assign push_item = item4_reg;

endmodule

// ----- src/p16e10_queue.sv -----
// Short queue between front and back end.
module p16e10_queue #(
    parameter int DEPTH = p16e10_pkg::QDepth
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  p16e10_pkg::qitem_t  push_item,
    output logic                full,
    input  logic                pop,
    output p16e10_pkg::qitem_t  head,
    output logic                empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    p16e10_pkg::qitem_t mem [DEPTH];
    logic [PW-1:0] wr_reg, rd_reg;
    logic [CW-1:0] count_reg;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= (wr_reg == PW'(DEPTH - 1)) ? '0 : wr_reg + PW'(1);
            end
            if (pop)
            begin
                rd_reg <= (rd_reg == PW'(DEPTH - 1)) ? '0 : rd_reg + PW'(1);
            end
            count_reg <= count_reg + CW'(push) - CW'(pop);
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
        else $error("queue pop while empty");
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> count_reg == CW'($past(count_reg) + CW'($past(push)) - CW'($past(pop))))
        else $error("queue count mismatch");
`endif

endmodule

// ----- src/p16e10_back.sv -----
// Back end: polynomial, decimal to binary conversion, posit rounding.
module p16e10_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_empty,
    input  p16e10_pkg::qitem_t  head,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [15:0]         result_posit
);

    localparam int NH  = 6;
    localparam int ND  = 5;
    localparam int NST = 2 * NH + ND + 4;

    logic [NST-1:0] vld_reg;
    logic           b_en;

    assign b_en      = !vld_reg[NST-1] || out_ready;
    assign pop       = b_en && !q_empty;
    assign out_valid = vld_reg[NST-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (b_en)
        begin
            vld_reg <= {vld_reg[NST-2:0], pop};
        end
    end

    // Horner steps
    logic [63:0]       ya [NH];
    logic [63:0]       fa [NH];
    p16e10_pkg::side_t sa [NH];
    logic [63:0]       p00_reg [NH], p01_reg [NH], p10_reg [NH], p11_reg [NH];
    logic [63:0]       fp_reg [NH];
    p16e10_pkg::side_t sp_reg [NH];
    logic [63:0]       y_reg [NH];
    logic [63:0]       fy_reg [NH];
    p16e10_pkg::side_t sy_reg [NH];

    for (genvar j = 0; j < NH; j++)
    begin : g_horner
        logic [63:0] mid, y_next;

        if (j == 0)
        begin : g_first
            assign ya[j] = p16e10_pkg::COEF[NH];
            assign fa[j] = head.f64;
            assign sa[j] = head.side;
        end
        else
        begin : g_rest
            assign ya[j] = y_reg[j-1];
            assign fa[j] = fy_reg[j-1];
            assign sa[j] = sy_reg[j-1];
        end

        always_ff @(posedge clk)
        begin
            if (b_en)
            begin
                p00_reg[j] <= {32'b0, ya[j][31:0]}  * {32'b0, fa[j][31:0]};
                p01_reg[j] <= {32'b0, ya[j][31:0]}  * {32'b0, fa[j][63:32]};
                p10_reg[j] <= {32'b0, ya[j][63:32]} * {32'b0, fa[j][31:0]};
                p11_reg[j] <= {32'b0, ya[j][63:32]} * {32'b0, fa[j][63:32]};
                fp_reg[j]  <= fa[j];
                sp_reg[j]  <= sa[j];
            end
        end

        assign mid = {32'b0, p00_reg[j][63:32]} + {32'b0, p01_reg[j][31:0]}
                   + {32'b0, p10_reg[j][31:0]};
        assign y_next = p11_reg[j] + {32'b0, p01_reg[j][63:32]} + {32'b0, p10_reg[j][63:32]}
                      + {32'b0, mid[63:32]} + p16e10_pkg::COEF[NH-1-j];

        always_ff @(posedge clk)
        begin
            if (b_en)
            begin
                y_reg[j]  <= y_next;
                fy_reg[j] <= fp_reg[j];
                sy_reg[j] <= sp_reg[j];
            end
        end
    end

    // D1: y times reciprocal of 5^18, partial products
    logic [61:0]       yin;
    logic [61:0]       yd1_reg;
    logic [63:0]       cll_reg, clh_reg, chl_reg, chh_reg;
    p16e10_pkg::side_t sd1_reg;

    assign yin = y_reg[NH-1][61:0];

    always_ff @(posedge clk)
    begin
        if (b_en)
        begin
            cll_reg <= {32'b0, yin[31:0]}  * {32'b0, p16e10_pkg::DEC_RECIP[31:0]};
            clh_reg <= {32'b0, yin[31:0]}  * {33'b0, p16e10_pkg::DEC_RECIP[62:32]};
            chl_reg <= {34'b0, yin[61:32]} * {32'b0, p16e10_pkg::DEC_RECIP[31:0]};
            chh_reg <= {34'b0, yin[61:32]} * {33'b0, p16e10_pkg::DEC_RECIP[62:32]};
            yd1_reg <= yin;
            sd1_reg <= sy_reg[NH-1];
        end
    end

    // D2: quotient estimate, exact or one too large
    logic [127:0]      yc;
    logic [62:0]       mest2_reg;
    logic [61:0]       yd2_reg;
    p16e10_pkg::side_t sd2_reg;

    assign yc = {64'b0, cll_reg} + {32'b0, clh_reg, 32'b0} + {32'b0, chl_reg, 32'b0}
              + {chh_reg, 64'b0};

    always_ff @(posedge clk)
    begin
        if (b_en)
        begin
            mest2_reg <= yc[124:62];
            yd2_reg   <= yd1_reg;
            sd2_reg   <= sd1_reg;
        end
    end

    // D3: estimate times 5^18, partial products
    logic [63:0]       dll_reg, dlh_reg, dhl_reg, dhh_reg;
    logic [62:0]       mest3_reg;
    logic [61:0]       yd3_reg;
    p16e10_pkg::side_t sd3_reg;

    always_ff @(posedge clk)
    begin
        if (b_en)
        begin
            dll_reg   <= {32'b0, mest2_reg[31:0]}  * {32'b0, p16e10_pkg::DEC_Q[31:0]};
            dlh_reg   <= {32'b0, mest2_reg[31:0]}  * {54'b0, p16e10_pkg::DEC_Q[41:32]};
            dhl_reg   <= {33'b0, mest2_reg[62:32]} * {32'b0, p16e10_pkg::DEC_Q[31:0]};
            dhh_reg   <= {33'b0, mest2_reg[62:32]} * {54'b0, p16e10_pkg::DEC_Q[41:32]};
            mest3_reg <= mest2_reg;
            yd3_reg   <= yd2_reg;
            sd3_reg   <= sd2_reg;
        end
    end

    // D4: sum back product
    logic [127:0]      md4_reg;
    logic [62:0]       mest4_reg;
    logic [61:0]       yd4_reg;
    p16e10_pkg::side_t sd4_reg;

    always_ff @(posedge clk)
    begin
        if (b_en)
        begin
            md4_reg   <= {64'b0, dll_reg} + {32'b0, dlh_reg, 32'b0} + {32'b0, dhl_reg, 32'b0}
                       + {dhh_reg, 64'b0};
            mest4_reg <= mest3_reg;
            yd4_reg   <= yd3_reg;
            sd4_reg   <= sd3_reg;
        end
    end

    // D5: correct estimate, remainder flag
    logic [127:0]      nn;
    logic              over;
    logic [61:0]       m5_reg;
    logic              st5_reg;
    p16e10_pkg::side_t sd5_reg;

    assign nn   = {24'b0, yd4_reg, 42'b0};
    assign over = (md4_reg > nn);

    always_ff @(posedge clk)
    begin
        if (b_en)
        begin
            m5_reg  <= 62'(mest4_reg - {62'b0, over});
            st5_reg <= (md4_reg != nn);
            sd5_reg <= sd4_reg;
        end
    end

    // R1: leading zero count
    logic [61:0]       m1_reg;
    logic              st1_reg;
    logic [5:0]        lz1_reg;
    p16e10_pkg::side_t s1_reg;

    always_ff @(posedge clk)
    begin
        if (b_en)
        begin
            m1_reg  <= m5_reg;
            st1_reg <= st5_reg;
            lz1_reg <= p16e10_pkg::lzc62(m5_reg);
            s1_reg  <= sd5_reg;
        end
    end

    // R2: normalize, exponent split
    logic [61:0]       mn;
    logic signed [8:0] ex;
    logic [39:0]       fr2_reg;
    logic              st2_reg, re2_reg, mz2_reg;
    logic signed [7:0] rk2_reg;
    p16e10_pkg::side_t s2_reg;

    assign mn = m1_reg << lz1_reg;
    assign ex = {s1_reg.n[7], s1_reg.n} + 9'sd1 - $signed({3'b0, lz1_reg});

    always_ff @(posedge clk)
    begin
        if (b_en)
        begin
            fr2_reg <= mn[60:21];
            st2_reg <= st1_reg || (mn[20:0] != '0);
            rk2_reg <= ex[8:1];
            re2_reg <= ex[0];
            mz2_reg <= (m1_reg == '0);
            s2_reg  <= s1_reg;
        end
    end

    // R3: assemble posit string
    logic [15:0]       reg16;
    logic [3:0]        len;
    logic [7:0]        negr;
    logic [55:0]       tail, tstr;
    logic              fix_next;
    logic [15:0]       fixv_next;
    logic [14:0]       keep3_reg;
    logic              g3_reg, st3_reg, fix3_reg;
    logic [15:0]       fixv3_reg;

    always_comb
    begin
        negr = 8'(-rk2_reg);
        if (rk2_reg >= 8'sd0)
        begin
            reg16 = 16'hFFFF << (4'd15 - rk2_reg[3:0]);
            len   = rk2_reg[3:0] + 4'd2;
        end
        else
        begin
            reg16 = 16'h8000 >> negr[3:0];
            len   = 4'd1 + negr[3:0];
        end
        tail = {re2_reg, fr2_reg, 15'b0} >> len;
        tstr = {reg16, 40'b0} | tail;

        fix_next  = 1'b1;
        fixv_next = p16e10_pkg::MINPOS;
        if (s2_reg.spec)
        begin
            fixv_next = s2_reg.spec_res;
        end
        else if (mz2_reg)
        begin
            fixv_next = p16e10_pkg::MINPOS;
        end
        else if (rk2_reg >= 8'sd14)
        begin
            fixv_next = p16e10_pkg::MAXPOS;
        end
        else if (rk2_reg <= -8'sd15)
        begin
            fixv_next = p16e10_pkg::MINPOS;
        end
        else
        begin
            fix_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_en)
        begin
            keep3_reg <= tstr[55:41];
            g3_reg    <= tstr[40];
            st3_reg   <= st2_reg || (tstr[39:0] != '0);
            fix3_reg  <= fix_next;
            fixv3_reg <= fixv_next;
        end
    end

    // R4: round to nearest even, saturate
    logic [15:0] rnd, res_next, res_reg;

    always_comb
    begin
        rnd = {1'b0, keep3_reg} + 16'(g3_reg && (st3_reg || keep3_reg[0]));
        if (fix3_reg)
        begin
            res_next = fixv3_reg;
        end
        else if (rnd > p16e10_pkg::MAXPOS)
        begin
            res_next = p16e10_pkg::MAXPOS;
        end
        else if (rnd == 16'd0)
        begin
            res_next = p16e10_pkg::MINPOS;
        end
        else
        begin
            res_next = rnd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_en)
        begin
            res_reg <= res_next;
        end
    end

    assign result_posit = res_reg;

endmodule
